// File: hw/rtl/spdc_pkg.sv
// ----------------------------------------------------------------------------
// spdc_pkg
// Shared constants for the site pattern dedup counter.
// ----------------------------------------------------------------------------
`default_nettype none
package spdc_pkg;
  localparam int unsigned MAX_TAXA_DEF     = 16;
  localparam int unsigned MAX_PATTERNS_DEF = 256;
  localparam int unsigned COUNT_BITS_DEF   = 16;

  localparam logic [3:0] CODE_GAP     = 4'd4;
  localparam logic [3:0] CODE_UNKNOWN = 4'd15;

  localparam logic [1:0] ST_EXCLUDED = 2'd0;
  localparam logic [1:0] ST_NEW      = 2'd1;
  localparam logic [1:0] ST_REPEAT   = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam int unsigned CFG_AW = 3;
  localparam logic [CFG_AW-1:0] ADDR_GAP_MODE = 3'd0;
  localparam logic [CFG_AW-1:0] ADDR_NUM_TAXA = 3'd4;

  localparam logic [4:0] NUM_TAXA_RST = 5'd4;
endpackage
`default_nettype wire

// File: hw/rtl/spdc_fifo.sv
// ----------------------------------------------------------------------------
// spdc_fifo
// Two-entry queue between the column builder and the pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none
module spdc_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);
  logic [WIDTH-1:0] mem_r [2];
  logic             wptr_r, rptr_r;
  logic [1:0]       cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push && !full) wptr_r <= ~wptr_r;
      if (pop && !empty) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, (push && !full)} - {1'b0, (pop && !empty)};
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/spdc_front.sv
// ----------------------------------------------------------------------------
// spdc_front
// Collects codes into a column, grades eligibility, queues complete columns.
// ----------------------------------------------------------------------------
`default_nettype none
module spdc_front
  import spdc_pkg::*;
#(
  parameter int unsigned MAX_TAXA = MAX_TAXA_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    gap_mode,
  input  wire logic [4:0]              num_taxa,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [3:0]              code,
  input  wire logic                    first,
  input  wire logic                    q_full,
  output logic                         q_push,
  output logic [MAX_TAXA*5+1:0]        q_wdata
);
  localparam int unsigned POS_W  = $clog2(MAX_TAXA + 1);
  localparam int unsigned TW     = (POS_W > 5) ? POS_W : 5;
  localparam int unsigned PIDX_W = (MAX_TAXA > 1) ? $clog2(MAX_TAXA) : 1;

  logic [3:0]       col_r [MAX_TAXA];
  logic [POS_W-1:0] pos_r, pos;
  logic             has_gap_r, all_gap_r, pend_clr_r;
  logic             has_gap, all_gap, done, elig, acc;
  logic [TW-1:0]    taxa, nt_w, pos_w, pos_inc;
  logic [MAX_TAXA*4-1:0] col_word;
  logic [MAX_TAXA-1:0]   mask_word;  // codes that take part in the match

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    nt_w = TW'(num_taxa);
    if (nt_w == '0)                 taxa = TW'(1);
    else if (nt_w > TW'(MAX_TAXA))  taxa = TW'(MAX_TAXA);
    else                            taxa = nt_w;
    pos     = first ? '0 : pos_r;
    if (TW'(pos) >= TW'(MAX_TAXA)) pos = '0;
    has_gap = (first ? 1'b0 : has_gap_r) || code == CODE_GAP || code == CODE_UNKNOWN;
    all_gap = (first ? 1'b1 : all_gap_r) && code == CODE_GAP;
    pos_w   = TW'(pos);
    pos_inc = pos_w + TW'(1);
    done    = (pos_inc >= taxa);
    elig    = gap_mode ? !all_gap : !has_gap;
    for (int i = 0; i < MAX_TAXA; i++) begin
      mask_word[i] = (TW'(i) < taxa);
      if (TW'(i) >= taxa)      col_word[i*4 +: 4] = 4'd0;
      else if (TW'(i) == pos_w) col_word[i*4 +: 4] = code;
      else                     col_word[i*4 +: 4] = col_r[i];
    end
  end

  assign q_push  = acc && done;
  assign q_wdata = {pend_clr_r || first, elig, mask_word, col_word};

  always_ff @(posedge clk) begin
    if (acc) col_r[PIDX_W'(pos)] <= code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      has_gap_r  <= 1'b0;
      all_gap_r  <= 1'b1;
      pend_clr_r <= 1'b0;
    end else if (acc) begin
      if (done) begin
        pos_r      <= '0;
        has_gap_r  <= 1'b0;
        all_gap_r  <= 1'b1;
        pend_clr_r <= 1'b0;
      end else begin
        pos_r      <= POS_W'(pos_inc);
        has_gap_r  <= has_gap;
        all_gap_r  <= all_gap;
        pend_clr_r <= pend_clr_r || first;
      end
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/spdc_back.sv
// ----------------------------------------------------------------------------
// spdc_back
// Scans the pattern table for a queued column; stores or counts the pattern.
// ----------------------------------------------------------------------------
`default_nettype none
module spdc_back
  import spdc_pkg::*;
#(
  parameter int unsigned MAX_TAXA     = MAX_TAXA_DEF,
  parameter int unsigned MAX_PATTERNS = MAX_PATTERNS_DEF,
  parameter int unsigned COUNT_BITS   = COUNT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_empty,
  input  wire logic [MAX_TAXA*5+1:0] q_rdata,
  output logic                      q_pop,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [23:0]               out_tdata,
  output logic [1:0]                out_tuser
);
  localparam int unsigned CW    = MAX_TAXA * 4;
  localparam int unsigned MW    = MAX_TAXA;
  localparam int unsigned IDX_W = $clog2(MAX_PATTERNS);
  localparam int unsigned TOT_W = $clog2(MAX_PATTERNS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_CRD  = 2'd2;
  localparam logic [1:0] S_CUPD = 2'd3;

  logic [CW-1:0]         pat_mem [MAX_PATTERNS];
  logic [COUNT_BITS-1:0] cnt_mem [MAX_PATTERNS];

  logic [1:0]            state_r, state_nxt;
  logic [CW-1:0]         col_r, col_nxt, row_q;
  logic [MW-1:0]         msk_r, msk_nxt;
  logic                  row_hit;
  logic [TOT_W-1:0]      total_r, total_nxt, scan_r, scan_nxt;
  logic [IDX_W-1:0]      row_idx_r, row_idx_nxt, hit_r, hit_nxt;
  logic                  row_vld_r, row_vld_nxt;
  logic [COUNT_BITS-1:0] cnt_q, cnt_inc;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  pw_en, cw_en;
  logic [IDX_W-1:0]      w_addr;
  logic [COUNT_BITS-1:0] cw_data;

  logic                  ov_r, ov_nxt;
  logic [1:0]            ost_r, ost_nxt;
  logic [IDX_W-1:0]      oidx_r, oidx_nxt;
  logic [COUNT_BITS-1:0] ocnt_r, ocnt_nxt;
  logic [IDX_W+7:0]      idx_ext;
  logic [COUNT_BITS+15:0] cnt_ext;

  assign cnt_inc = (&cnt_q) ? cnt_q : cnt_q + COUNT_BITS'(1);

  // only the codes of the current column width are compared
  always_comb begin
    row_hit = 1'b1;
    for (int i = 0; i < MAX_TAXA; i++) begin
      if (msk_r[i] && row_q[i*4 +: 4] != col_r[i*4 +: 4]) row_hit = 1'b0;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    col_nxt     = col_r;
    msk_nxt     = msk_r;
    total_nxt   = total_r;
    scan_nxt    = scan_r;
    row_idx_nxt = row_idx_r;
    row_vld_nxt = 1'b0;
    hit_nxt     = hit_r;
    ov_nxt      = ov_r && !out_tready;
    ost_nxt     = ost_r;
    oidx_nxt    = oidx_r;
    ocnt_nxt    = ocnt_r;
    q_pop       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = IDX_W'(scan_r);
    pw_en       = 1'b0;
    cw_en       = 1'b0;
    w_addr      = IDX_W'(total_r);
    cw_data     = COUNT_BITS'(1);
    case (state_r)
      S_IDLE: begin
        if (!q_empty && !ov_r) begin
          q_pop   = 1'b1;
          col_nxt = q_rdata[CW-1:0];
          msk_nxt = q_rdata[CW+MW-1:CW];
          if (q_rdata[CW+MW+1]) total_nxt = '0;
          scan_nxt = '0;
          if (q_rdata[CW+MW]) begin
            state_nxt = S_SCAN;
          end else begin
            ov_nxt   = 1'b1;
            ost_nxt  = ST_EXCLUDED;
            oidx_nxt = '0;
            ocnt_nxt = '0;
          end
        end
      end
      S_SCAN: begin
        if (row_vld_r && row_hit) begin
          hit_nxt   = row_idx_r;
          state_nxt = S_CRD;
        end else if (scan_r < total_r) begin
          rd_en       = 1'b1;
          row_idx_nxt = IDX_W'(scan_r);
          row_vld_nxt = 1'b1;
          scan_nxt    = scan_r + TOT_W'(1);
        end else begin
          state_nxt = S_IDLE;
          ov_nxt    = 1'b1;
          if (total_r < TOT_W'(MAX_PATTERNS)) begin
            pw_en     = 1'b1;
            cw_en     = 1'b1;
            ost_nxt   = ST_NEW;
            oidx_nxt  = IDX_W'(total_r);
            ocnt_nxt  = COUNT_BITS'(1);
            total_nxt = total_r + TOT_W'(1);
          end else begin
            ost_nxt  = ST_FULL;
            oidx_nxt = '0;
            ocnt_nxt = '0;
          end
        end
      end
      S_CRD: begin
        state_nxt = S_CUPD;
      end
      S_CUPD: begin
        cw_en     = 1'b1;
        w_addr    = hit_r;
        cw_data   = cnt_inc;
        ov_nxt    = 1'b1;
        ost_nxt   = ST_REPEAT;
        oidx_nxt  = hit_r;
        ocnt_nxt  = cnt_inc;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // pattern rows: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (pw_en) pat_mem[w_addr] <= col_r;
    if (rd_en) row_q <= pat_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cw_en) cnt_mem[w_addr] <= cw_data;
    cnt_q <= cnt_mem[hit_r];
  end

  always_ff @(posedge clk) begin
    col_r     <= col_nxt;
    msk_r     <= msk_nxt;
    scan_r    <= scan_nxt;
    row_idx_r <= row_idx_nxt;
    hit_r     <= hit_nxt;
    ost_r     <= ost_nxt;
    oidx_r    <= oidx_nxt;
    ocnt_r    <= ocnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      total_r   <= '0;
      row_vld_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      total_r   <= total_nxt;
      row_vld_r <= row_vld_nxt;
      ov_r      <= ov_nxt;
    end
  end

  assign idx_ext    = {8'd0, oidx_r};
  assign cnt_ext    = {16'd0, ocnt_r};
  assign out_tvalid = ov_r;
  assign out_tuser  = ost_r;
  assign out_tdata  = {cnt_ext[15:0], idx_ext[7:0]};
endmodule
`default_nettype wire

// File: hw/rtl/site_pattern_dedup_counter.sv
// ----------------------------------------------------------------------------
// site_pattern_dedup_counter
// Alignment site pattern compression: column builder, queue, pattern matcher.
// ----------------------------------------------------------------------------
// Codes stream in one per transaction and fill a column of num_taxa codes;
// each finished column yields exactly one result transaction (excluded, new
// pattern, repeat, or table full). The front takes one code per cycle while
// the queue is not full; the matcher then walks the stored patterns one per
// cycle through a registered memory read, and a repeat adds a count update;
// this work overlaps the next column's codes through a two-entry queue.
// first_of_alignment empties the table before the column it starts. Config:
// gap mode bit at 0x0, num_taxa at 0x4; write only while idle. No clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module site_pattern_dedup_counter
  import spdc_pkg::*;
#(
  parameter int unsigned MAX_TAXA     = MAX_TAXA_DEF,
  parameter int unsigned MAX_PATTERNS = MAX_PATTERNS_DEF,
  parameter int unsigned COUNT_BITS   = COUNT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input stream
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,   // [3:0] base_code, [7:4] zero
  input  wire logic              in_tuser,   // [0] first_of_alignment
  // result stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [23:0]            out_tdata,  // [7:0] pattern_index, [23:8] pattern_count
  output logic [1:0]             out_tuser,  // [1:0] column_status
  // configuration
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);
  // queue entry: column codes, match mask, eligible flag, table clear flag
  localparam int unsigned QW = MAX_TAXA * 5 + 2;

  logic          incl_gaps_r;
  logic [4:0]    num_taxa_r;
  logic          cfg_wr;
  logic          q_push, q_pop, q_full, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  // register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      incl_gaps_r <= 1'b0;
      num_taxa_r  <= NUM_TAXA_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr == ADDR_GAP_MODE) incl_gaps_r <= cfg_pwdata[0];
      if (cfg_paddr == ADDR_NUM_TAXA) num_taxa_r  <= cfg_pwdata[4:0];
    end
  end

  always_comb begin
    case (cfg_paddr)
      ADDR_GAP_MODE: cfg_prdata = {31'd0, incl_gaps_r};
      ADDR_NUM_TAXA: cfg_prdata = {27'd0, num_taxa_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  spdc_front #(.MAX_TAXA(MAX_TAXA)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .gap_mode     (incl_gaps_r),
    .num_taxa     (num_taxa_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .code         (in_tdata[3:0]),
    .first        (in_tuser),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  spdc_fifo #(.WIDTH(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  spdc_back #(
    .MAX_TAXA     (MAX_TAXA),
    .MAX_PATTERNS (MAX_PATTERNS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );
endmodule
`default_nettype wire

// File: bench/tb_site_pattern_dedup_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_site_pattern_dedup_counter
// Self-checking bench for the site pattern dedup counter.
// ----------------------------------------------------------------------------
// Streams nucleotide codes into the block over several register settings and
// holds its own model of the column builder and pattern table to predict
// every result transaction. It runs a directed opening and a long random
// stretch with idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_site_pattern_dedup_counter;
  import spdc_pkg::*;

  localparam int TAXA_LIMIT   = 16;
  localparam int TABLE_DEPTH  = 256;
  localparam int DRAIN_CYCLES = 300;  // worst matcher walk plus margin

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  index;
    logic [15:0] count;
  } column_result_t;

  // Column builder and pattern table, tracked alongside the block
  class pattern_tally;
    bit             keep_gapped;
    logic [4:0]     taxa_reg;
    logic [3:0]     column_codes [TAXA_LIMIT];
    logic [3:0]     patterns [TABLE_DEPTH][TAXA_LIMIT];
    logic [15:0]    tallies [TABLE_DEPTH];
    int unsigned    stored;
    int unsigned    fill;
    bit             saw_gap;
    bit             only_gaps;
    column_result_t awaiting[$];
    int             errors;
    int             results_seen;
    int             status_seen [4];

    function new();
      keep_gapped = 1'b0;
      taxa_reg    = NUM_TAXA_RST;
      stored      = 0;
      errors      = 0;
      results_seen = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      restart();
    endfunction

    function void restart();
      fill      = 0;
      saw_gap   = 1'b0;
      only_gaps = 1'b1;
    endfunction

    function int unsigned taxa_now();
      if (taxa_reg == 0) return 1;
      if (taxa_reg > TAXA_LIMIT) return TAXA_LIMIT;
      return taxa_reg;
    endfunction

    // One accepted code transaction; queues a result when a column closes
    function void note_code(logic [3:0] code, bit first);
      int unsigned    t;
      int unsigned    p;
      bit             hit;
      bit             same;
      column_result_t r;
      if (first) begin
        stored = 0;
        restart();
      end
      t = taxa_now();
      if (fill >= TAXA_LIMIT) fill = 0;
      column_codes[fill] = code;
      if (code == CODE_GAP || code == CODE_UNKNOWN) saw_gap = 1'b1;
      if (code != CODE_GAP) only_gaps = 1'b0;
      fill++;
      if (fill < t) return;
      r = '0;
      r.status = ST_EXCLUDED;
      if (keep_gapped ? !only_gaps : !saw_gap) begin
        hit = 1'b0;
        for (p = 0; p < stored; p++) begin
          same = 1'b1;
          for (int i = 0; i < t; i++)
            if (patterns[p][i] != column_codes[i]) same = 1'b0;
          if (same) begin
            hit = 1'b1;
            break;
          end
        end
        if (hit) begin
          if (tallies[p] != 16'hFFFF) tallies[p]++;
          r.status = ST_REPEAT;
          r.index  = p[7:0];
          r.count  = tallies[p];
        end else if (stored < TABLE_DEPTH) begin
          for (int i = 0; i < t; i++) patterns[stored][i] = column_codes[i];
          tallies[stored] = 16'd1;
          r.status = ST_NEW;
          r.index  = stored[7:0];
          r.count  = 16'd1;
          stored++;
        end else begin
          r.status = ST_FULL;
        end
      end
      restart();
      awaiting.push_back(r);
    endfunction

    function void check_result(column_result_t got);
      column_result_t want;
      results_seen++;
      status_seen[got.status]++;
      if (awaiting.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status=%0d index=%0d count=%0d",
                 $time, got.status, got.index, got.count);
        return;
      end
      want = awaiting.pop_front();
      if (got.status != want.status) begin
        errors++;
        $display("%0t: column_status expected %0d actual %0d", $time,
                 want.status, got.status);
      end
      if (got.index != want.index) begin
        errors++;
        $display("%0t: pattern_index expected %0d actual %0d", $time,
                 want.index, got.index);
      end
      if (got.count != want.count) begin
        errors++;
        $display("%0t: pattern_count expected %0d actual %0d", $time,
                 want.count, got.count);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;
  logic              in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [23:0]       out_tdata;
  logic [1:0]        out_tuser;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  pattern_tally tally;
  bit           src_idle_on;   // sender may insert gaps
  bit           snk_idle_on;   // receiver may stall
  bit           hold_req;      // receiver long hold-off request
  bit           open_alignment; // next code must start a new alignment
  int           codes_sent;
  int           cfg_errors;

  site_pattern_dedup_counter DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Watchdog: well beyond the slowest legal run (full table walk per code)
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Result side. Outputs are sampled at the falling edge, clear of the rising
  // edge at which the transaction actually completes.
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tally.check_result({out_tuser, out_tdata[7:0], out_tdata[23:8]});
  end

  // Receiver: random stalls, or a long counted hold-off when asked
  initial begin
    out_tready <= 1'b0;
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (snk_idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic int unsigned taxa_eff(logic [4:0] v);
    if (v == 0) return 1;
    if (v > TAXA_LIMIT) return TAXA_LIMIT;
    return v;
  endfunction

  // APB write then read-back; called at a rising edge, returns at one
  task automatic reg_access(logic [CFG_AW-1:0] addr, logic [31:0] val);
    logic [31:0] mask;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    mask = (addr == ADDR_NUM_TAXA) ? 32'h1F : 32'h1;
    if ((cfg_prdata & mask) != (val & mask)) begin
      cfg_errors++;
      $display("%0t: register 0x%0h expected 0x%0h actual 0x%0h", $time, addr,
               val & mask, cfg_prdata & mask);
    end
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_gaps(bit v);
    reg_access(ADDR_GAP_MODE, {31'd0, v});
    tally.keep_gapped = v;
  endtask

  // A raised taxa count would compare stored patterns past their written
  // length, so the next code opens a fresh alignment in that case.
  task automatic set_taxa(logic [4:0] v);
    if (taxa_eff(v) > taxa_eff(tally.taxa_reg)) open_alignment = 1'b1;
    reg_access(ADDR_NUM_TAXA, {27'd0, v});
    tally.taxa_reg = v;
  endtask

  // One code transaction, with an optional idle burst in front
  task automatic send_code(logic [3:0] code, bit first);
    bit took;
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    first = first | open_alignment;
    open_alignment = 1'b0;
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, code};
    in_tuser  <= first;
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    tally.note_code(code, first);
    codes_sent++;
  endtask

  // Quiet the input and wait until the block has nothing left in flight
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tally.awaiting.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_column(logic [3:0] a, logic [3:0] b, logic [3:0] c,
                             logic [3:0] d, bit first);
    send_code(a, first);
    send_code(b, 1'b0);
    send_code(c, 1'b0);
    send_code(d, 1'b0);
  endtask

  // Codes drawn mostly from a small alphabet so that columns repeat
  function automatic logic [3:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 4'($urandom_range(0, 1));
    if (r < 90) return 4'($urandom_range(2, 3));
    if (r < 95) return CODE_GAP;
    return 4'($urandom_range(0, 15));
  endfunction

  initial begin
    logic [4:0] taxa_pick;
    tally          = new();
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    src_idle_on    = 1'b0;
    snk_idle_on    = 1'b0;
    hold_req       = 1'b0;
    open_alignment = 1'b0;
    codes_sent     = 0;
    cfg_errors     = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: reset settings, taxa 4, gapped columns dropped ---
    send_column(4'd0, 4'd1, 4'd2, 4'd3, 1'b1);        // new pattern
    send_column(4'd0, 4'd1, 4'd2, 4'd3, 1'b0);        // repeat
    send_column(4'd0, CODE_GAP, 4'd2, 4'd3, 1'b0);    // gap excludes
    send_column(4'd5, 4'd14, CODE_UNKNOWN, 4'd3, 1'b0); // unknown excludes
    send_column(4'd5, 4'd9, 4'd12, 4'd14, 1'b0);      // ambiguity codes kept
    settle();
    // gapped columns kept, all-gap still dropped
    set_gaps(1'b1);
    send_column(CODE_GAP, CODE_GAP, CODE_GAP, CODE_GAP, 1'b0);
    send_column(CODE_GAP, 4'd1, CODE_UNKNOWN, CODE_GAP, 1'b0);
    settle();
    // zero taxa acts as one
    set_taxa(5'd0);
    send_code(4'd3, 1'b0);
    send_code(4'd3, 1'b0);
    settle();
    // oversized taxa saturates at the limit; leave a column half built
    set_taxa(5'd31);
    for (int i = 0; i < 21; i++) send_code(i[3:0], 1'b0);
    settle();
    // taxa lowered mid-column: the next code closes it
    set_taxa(5'd2);
    send_code(4'd7, 1'b0);
    send_code(4'd8, 1'b0);
    send_code(4'd8, 1'b0);
    settle();

    // --- random: new settings every chunk, idling on both sides ---
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    for (int chunk = 0; chunk < 7; chunk++) begin
      set_gaps(1'($urandom_range(0, 1)));
      case ($urandom_range(0, 5))
        0:       taxa_pick = 5'd1;
        1:       taxa_pick = 5'd16;
        2:       taxa_pick = 5'($urandom_range(17, 31));
        default: taxa_pick = 5'($urandom_range(2, 6));
      endcase
      set_taxa(taxa_pick);
      if (chunk == 6) snk_idle_on = 1'b0;   // no idling near the end
      if (chunk == 6) src_idle_on = 1'b0;
      for (int n = 0; n < 95; n++) begin
        if (chunk == 2 && n == 20) hold_req = 1'b1;
        send_code(pick_code(), ($urandom_range(0, 149) == 0));
      end
      settle();
    end

    if (tally.awaiting.size() != 0) begin
      tally.errors++;
      $display("%0t: %0d results never arrived", $time, tally.awaiting.size());
    end
    $display("Covered %0d codes and %0d columns: %0d excluded, %0d new, %0d repeat,",
             codes_sent, tally.results_seen, tally.status_seen[ST_EXCLUDED],
             tally.status_seen[ST_NEW], tally.status_seen[ST_REPEAT]);
    $display("%0d table full, across gap and taxa settings and output stalls.",
             tally.status_seen[ST_FULL]);
    if (tally.errors == 0 && cfg_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// File: sim.f
hw/rtl/spdc_pkg.sv
hw/rtl/spdc_fifo.sv
hw/rtl/spdc_front.sv
hw/rtl/spdc_back.sv
hw/rtl/site_pattern_dedup_counter.sv
bench/tb_site_pattern_dedup_counter.sv
